// ----- rtl/uri_stream_parser_core_macros.svh -----
// -----------------------------------------------------------------------------
// uri_stream_parser_core macros
// Assertion shorthands used by the parser core RTL.
// -----------------------------------------------------------------------------
`ifndef URI_STREAM_PARSER_CORE_MACROS_SVH
`define URI_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define USP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/usp_pkg.sv -----
// -----------------------------------------------------------------------------
// usp_pkg
// Types, codes and constants of the URI stream parser.
// -----------------------------------------------------------------------------
`default_nettype none

package usp_pkg;

  // parser states
  localparam logic [3:0] ST_SCHEME_START = 4'd0;
  localparam logic [3:0] ST_SCHEME       = 4'd1;
  localparam logic [3:0] ST_MARK         = 4'd2;
  localparam logic [3:0] ST_HOST         = 4'd3;
  localparam logic [3:0] ST_PORT         = 4'd4;
  localparam logic [3:0] ST_PATH         = 4'd5;
  localparam logic [3:0] ST_QUERY        = 4'd6;
  localparam logic [3:0] ST_FRAG         = 4'd7;
  localparam logic [3:0] ST_END          = 4'd8;

  // section codes on the result
  localparam logic [2:0] SEC_SCHEME = 3'd0;
  localparam logic [2:0] SEC_HOST   = 3'd1;
  localparam logic [2:0] SEC_PORT   = 3'd2;
  localparam logic [2:0] SEC_PATH   = 3'd3;
  localparam logic [2:0] SEC_QUERY  = 3'd4;
  localparam logic [2:0] SEC_FRAG   = 3'd5;
  localparam logic [2:0] SEC_DELIM  = 3'd6;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_SCHEME     = 4'd1;
  localparam logic [3:0] ERR_MARKER     = 4'd2;
  localparam logic [3:0] ERR_PERCENT    = 4'd3;
  localparam logic [3:0] ERR_PORT_LARGE = 4'd4;
  localparam logic [3:0] ERR_PORT_CHAR  = 4'd5;
  localparam logic [3:0] ERR_AUTHORITY  = 4'd6;
  localparam logic [3:0] ERR_PATH       = 4'd7;
  localparam logic [3:0] ERR_QUERY      = 4'd8;

  // UTF-8 lead classes that narrow the first continuation byte
  localparam logic [2:0] U8_PLAIN = 3'd0;
  localparam logic [2:0] U8_E0    = 3'd1;
  localparam logic [2:0] U8_ED    = 3'd2;
  localparam logic [2:0] U8_F0    = 3'd3;
  localparam logic [2:0] U8_F4    = 3'd4;

  localparam logic [19:0] PORT_MAX = 20'd65535;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  typedef struct packed {
    logic [3:0]  st;
    logic [1:0]  mark;
    logic [1:0]  esc_ph;
    logic [3:0]  esc_hi;
    logic [1:0]  u8_rem;
    logic [2:0]  u8_cls;
    logic [16:0] port;
    logic [3:0]  err;
  } usp_state_t;

  localparam usp_state_t USP_STATE_RST = '{
    st: ST_SCHEME_START, mark: 2'd0, esc_ph: 2'd0, esc_hi: 4'd0,
    u8_rem: 2'd0, u8_cls: U8_PLAIN, port: 17'd0, err: ERR_NONE
  };

  typedef struct packed {
    logic       digit;
    logic       alpha;
    logic       alnum;
    logic       unres;
    logic       sub;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       lead_ok;
    logic [1:0] lead_rem;
    logic [2:0] lead_cls;
  } usp_cls_t;

  typedef struct packed {
    logic [2:0]  section;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [3:0]  error_code;
    logic [15:0] port_number;
    logic        uri_done;
    logic        uri_ok;
  } usp_res_t;

  function automatic logic [2:0] sec_code(input logic [3:0] st);
    logic [2:0] s;
    unique case (st) inside
      ST_SCHEME_START, ST_SCHEME: s = SEC_SCHEME;
      ST_HOST:  s = SEC_HOST;
      ST_PORT:  s = SEC_PORT;
      ST_PATH:  s = SEC_PATH;
      ST_QUERY: s = SEC_QUERY;
      ST_FRAG:  s = SEC_FRAG;
      default:  s = SEC_DELIM;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/usp_in_if.sv -----
// -----------------------------------------------------------------------------
// usp_in_if
// Byte request channel into the URI parser.
// -----------------------------------------------------------------------------
`default_nettype none

interface usp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/usp_out_if.sv -----
// -----------------------------------------------------------------------------
// usp_out_if
// Result request channel out of the URI parser.
// -----------------------------------------------------------------------------
`default_nettype none

interface usp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  section;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic [3:0]  error_code;
  logic [15:0] port_number;
  logic        uri_done;
  logic        uri_ok;

  modport source (output valid, output section, output data_byte, output data_valid,
                  output error_code, output port_number, output uri_done,
                  output uri_ok, input ready);
  modport sink   (input valid, input section, input data_byte, input data_valid,
                  input error_code, input port_number, input uri_done,
                  input uri_ok, output ready);
endinterface

`default_nettype wire

// ----- rtl/usp_classify.sv -----
// -----------------------------------------------------------------------------
// usp_classify
// Character classes, hex value and UTF-8 lead decode of one byte.
// -----------------------------------------------------------------------------
`default_nettype none

module usp_classify (
  input  wire logic [7:0]      byte_i,
  output usp_pkg::usp_cls_t    cls_o
);

  logic is_digit;
  logic is_alpha;
  logic lo_hex;
  logic up_hex;

  always_comb begin
    is_digit = (byte_i >= "0") && (byte_i <= "9");
    is_alpha = ((byte_i >= "a") && (byte_i <= "z")) || ((byte_i >= "A") && (byte_i <= "Z"));
    lo_hex   = (byte_i >= "a") && (byte_i <= "f");
    up_hex   = (byte_i >= "A") && (byte_i <= "F");

    cls_o.digit = is_digit;
    cls_o.alpha = is_alpha;
    cls_o.alnum = is_digit || is_alpha;
    cls_o.unres = is_digit || is_alpha || (byte_i == usp_pkg::CH_MINUS) ||
                  (byte_i == usp_pkg::CH_DOT) || (byte_i == usp_pkg::CH_USCORE) ||
                  (byte_i == usp_pkg::CH_TILDE);
    cls_o.sub   = (byte_i == "!") || (byte_i == "$") || (byte_i == "&") ||
                  (byte_i == 8'h27) || (byte_i == "(") || (byte_i == ")") ||
                  (byte_i == "*") || (byte_i == usp_pkg::CH_PLUS) || (byte_i == ",") ||
                  (byte_i == ";") || (byte_i == usp_pkg::CH_EQUAL);

    // letters: low nibble + 9 gives a..f / A..F
    cls_o.hex_ok  = is_digit || lo_hex || up_hex;
    cls_o.hex_val = is_digit ? byte_i[3:0] : (byte_i[3:0] + 4'd9);

    cls_o.lead_ok  = 1'b1;
    cls_o.lead_rem = 2'd0;
    cls_o.lead_cls = usp_pkg::U8_PLAIN;
    if ((byte_i >= 8'hC2) && (byte_i <= 8'hDF)) begin
      cls_o.lead_rem = 2'd1;
    end else if (byte_i == 8'hE0) begin
      cls_o.lead_rem = 2'd2;
      cls_o.lead_cls = usp_pkg::U8_E0;
    end else if (byte_i == 8'hED) begin
      cls_o.lead_rem = 2'd2;
      cls_o.lead_cls = usp_pkg::U8_ED;
    end else if ((byte_i >= 8'hE1) && (byte_i <= 8'hEF)) begin
      cls_o.lead_rem = 2'd2;
    end else if (byte_i == 8'hF0) begin
      cls_o.lead_rem = 2'd3;
      cls_o.lead_cls = usp_pkg::U8_F0;
    end else if ((byte_i >= 8'hF1) && (byte_i <= 8'hF3)) begin
      cls_o.lead_rem = 2'd3;
    end else if (byte_i == 8'hF4) begin
      cls_o.lead_rem = 2'd3;
      cls_o.lead_cls = usp_pkg::U8_F4;
    end else begin
      cls_o.lead_ok = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/usp_step.sv -----
// -----------------------------------------------------------------------------
// usp_step
// Next parser state and result for one byte.
// -----------------------------------------------------------------------------
`default_nettype none

module usp_step (
  input  wire usp_pkg::usp_state_t  cur_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 last_i,
  input  wire usp_pkg::usp_cls_t    cls_i,
  output usp_pkg::usp_state_t       nxt_o,
  output usp_pkg::usp_res_t         res_o
);

  function automatic logic [3:0] end_fail(input usp_pkg::usp_state_t s);
    logic [3:0] f;
    f = usp_pkg::ERR_NONE;
    case (s.st) inside
      usp_pkg::ST_SCHEME_START, usp_pkg::ST_SCHEME: f = usp_pkg::ERR_SCHEME;
      usp_pkg::ST_MARK: f = usp_pkg::ERR_MARKER;
      usp_pkg::ST_HOST, usp_pkg::ST_PATH, usp_pkg::ST_QUERY: begin
        if (s.esc_ph != 2'd0) begin
          f = usp_pkg::ERR_PERCENT;
        end else if (s.u8_rem != 2'd0) begin
          f = (s.st == usp_pkg::ST_PATH) ? usp_pkg::ERR_PATH : usp_pkg::ERR_QUERY;
        end
      end
      default: f = usp_pkg::ERR_NONE;
    endcase
    return f;
  endfunction

  usp_pkg::usp_state_t n;
  logic [3:0]  fail_c;
  logic [3:0]  end_c;
  logic [3:0]  ecode;
  logic [19:0] pv;
  logic [7:0]  esc_v;
  logic [7:0]  u8_lo;
  logic [7:0]  u8_hi;
  logic [1:0]  mk;

  always_comb begin
    n      = cur_i;
    res_o  = '0;
    res_o.section = usp_pkg::SEC_DELIM;
    fail_c = usp_pkg::ERR_NONE;
    end_c  = usp_pkg::ERR_NONE;
    pv     = ({3'd0, cur_i.port} << 3) + ({3'd0, cur_i.port} << 1) + {16'd0, byte_i[3:0]};
    esc_v  = {cur_i.esc_hi, cls_i.hex_val};
    mk     = cur_i.mark + 2'd1;
    ecode  = (cur_i.st == usp_pkg::ST_HOST) ? usp_pkg::ERR_AUTHORITY :
             ((cur_i.st == usp_pkg::ST_PATH) ? usp_pkg::ERR_PATH : usp_pkg::ERR_QUERY);
    u8_lo  = 8'h80;
    u8_hi  = 8'hBF;
    case (cur_i.u8_cls)
      usp_pkg::U8_E0: u8_lo = 8'hA0;
      usp_pkg::U8_ED: u8_hi = 8'h9F;
      usp_pkg::U8_F0: u8_lo = 8'h90;
      usp_pkg::U8_F4: u8_hi = 8'h8F;
      default: u8_lo = 8'h80;
    endcase

    if (n.st > usp_pkg::ST_END) begin
      n.st = usp_pkg::ST_END;
    end

    if ((n.err == usp_pkg::ERR_NONE) && (n.st != usp_pkg::ST_END)) begin
      if (byte_i == usp_pkg::CH_NUL) begin
        fail_c = end_fail(n);
        n.st   = usp_pkg::ST_END;
      end else begin
        case (n.st)
          usp_pkg::ST_SCHEME_START: begin
            if (cls_i.alpha) begin
              res_o.data_valid = 1'b1;
              res_o.data_byte  = byte_i;
              res_o.section    = usp_pkg::SEC_SCHEME;
              n.st = usp_pkg::ST_SCHEME;
            end else begin
              fail_c = usp_pkg::ERR_SCHEME;
            end
          end
          usp_pkg::ST_SCHEME: begin
            if (cls_i.alnum || (byte_i == usp_pkg::CH_PLUS) || (byte_i == usp_pkg::CH_MINUS) ||
                (byte_i == usp_pkg::CH_DOT)) begin
              res_o.data_valid = 1'b1;
              res_o.data_byte  = byte_i;
              res_o.section    = usp_pkg::SEC_SCHEME;
            end else if (byte_i == usp_pkg::CH_COLON) begin
              n.st   = usp_pkg::ST_MARK;
              n.mark = 2'd0;
            end else begin
              fail_c = usp_pkg::ERR_SCHEME;
            end
          end
          usp_pkg::ST_MARK: begin
            if (byte_i == usp_pkg::CH_SLASH) begin
              n.mark = mk;
              if (mk >= 2'd2) begin
                n.st   = usp_pkg::ST_HOST;
                n.mark = 2'd0;
              end
            end else begin
              fail_c = usp_pkg::ERR_MARKER;
            end
          end
          usp_pkg::ST_PORT: begin
            if (cls_i.digit) begin
              if (pv > usp_pkg::PORT_MAX) begin
                fail_c = usp_pkg::ERR_PORT_LARGE;
              end else begin
                n.port = pv[16:0];
                res_o.data_valid = 1'b1;
                res_o.data_byte  = byte_i;
                res_o.section    = usp_pkg::SEC_PORT;
              end
            end else if (byte_i == usp_pkg::CH_SLASH) begin
              n.st = usp_pkg::ST_PATH;
            end else begin
              fail_c = usp_pkg::ERR_PORT_CHAR;
            end
          end
          usp_pkg::ST_FRAG: begin
            res_o.data_valid = 1'b1;
            res_o.data_byte  = byte_i;
            res_o.section    = usp_pkg::SEC_FRAG;
          end
          default: begin
            // host, path and query content
            if (n.esc_ph == 2'd1) begin
              if (!cls_i.hex_ok) begin
                fail_c = usp_pkg::ERR_PERCENT;
              end else begin
                n.esc_hi = cls_i.hex_val;
                n.esc_ph = 2'd2;
              end
            end else if (n.esc_ph == 2'd2) begin
              if (!cls_i.hex_ok) begin
                fail_c = usp_pkg::ERR_PERCENT;
              end else begin
                n.esc_ph = 2'd0;
                n.esc_hi = 4'd0;
                if (esc_v == 8'd0) begin
                  fail_c = usp_pkg::ERR_PERCENT;
                end else begin
                  res_o.data_valid = 1'b1;
                  res_o.data_byte  = esc_v;
                  res_o.section    = usp_pkg::sec_code(n.st);
                end
              end
            end else if (n.u8_rem != 2'd0) begin
              if ((byte_i < u8_lo) || (byte_i > u8_hi)) begin
                fail_c = ecode;
              end else begin
                n.u8_rem = n.u8_rem - 2'd1;
                n.u8_cls = usp_pkg::U8_PLAIN;
                res_o.data_valid = 1'b1;
                res_o.data_byte  = byte_i;
                res_o.section    = usp_pkg::sec_code(n.st);
              end
            end else if (cls_i.unres || cls_i.sub) begin
              res_o.data_valid = 1'b1;
              res_o.data_byte  = byte_i;
              res_o.section    = usp_pkg::sec_code(n.st);
            end else if (byte_i == usp_pkg::CH_PERCENT) begin
              n.esc_ph = 2'd1;
            end else if (n.st == usp_pkg::ST_HOST) begin
              if (byte_i == usp_pkg::CH_COLON) begin
                n.st = usp_pkg::ST_PORT;
              end else if (byte_i == usp_pkg::CH_SLASH) begin
                n.st = usp_pkg::ST_PATH;
              end else begin
                fail_c = usp_pkg::ERR_AUTHORITY;
              end
            end else if ((byte_i == usp_pkg::CH_SLASH) ||
                         ((byte_i == usp_pkg::CH_QMARK) && (n.st == usp_pkg::ST_QUERY))) begin
              res_o.data_valid = 1'b1;
              res_o.data_byte  = byte_i;
              res_o.section    = usp_pkg::sec_code(n.st);
            end else if (byte_i == usp_pkg::CH_QMARK) begin
              n.st = usp_pkg::ST_QUERY;
            end else if (byte_i == usp_pkg::CH_HASH) begin
              n.st = usp_pkg::ST_FRAG;
            end else if (cls_i.lead_ok) begin
              n.u8_rem = cls_i.lead_rem;
              n.u8_cls = cls_i.lead_cls;
              res_o.data_valid = 1'b1;
              res_o.data_byte  = byte_i;
              res_o.section    = usp_pkg::sec_code(n.st);
            end else begin
              fail_c = ecode;
            end
          end
        endcase
      end
      if (fail_c != usp_pkg::ERR_NONE) begin
        n.err = fail_c;
        if ((fail_c == usp_pkg::ERR_PORT_LARGE) || (fail_c == usp_pkg::ERR_PORT_CHAR)) begin
          n.port = 17'd0;
        end
      end
    end

    // last byte closes the string unless it already ended or failed
    if (last_i && (n.err == usp_pkg::ERR_NONE) && (n.st != usp_pkg::ST_END)) begin
      end_c = end_fail(n);
      n.st  = usp_pkg::ST_END;
      if (end_c != usp_pkg::ERR_NONE) begin
        n.err = end_c;
      end
    end

    res_o.error_code  = n.err;
    res_o.port_number = n.port[15:0];
    res_o.uri_done    = last_i;
    res_o.uri_ok      = last_i && (n.err == usp_pkg::ERR_NONE);

    nxt_o = last_i ? usp_pkg::USP_STATE_RST : n;
  end

endmodule

`default_nettype wire

// ----- rtl/uri_stream_parser_core.sv -----
// -----------------------------------------------------------------------------
// uri_stream_parser_core: byte-serial URI checker and splitter
// Path: a taken byte is captured in byte1, then its result is registered in res.
// Throughput: 1 byte per cycle while the result side does not stall.
// Backpressure on the result side holds both registers; no bubble when it clears.
// Reset: synchronous, active low; the parser returns to scheme start, no error.
// -----------------------------------------------------------------------------
`default_nettype none

`include "uri_stream_parser_core_macros.svh"

module uri_stream_parser_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  usp_in_if.sink       in_ch,
  usp_out_if.source    out_ch
);

  // Two registers: input capture (byte1) and result (res). The parser state
  // advances when the captured byte moves into the result register.

  logic                 v1_r, v1_nxt;
  logic [7:0]           byte1_r;
  logic                 last1_r;
  logic                 out_v_r, out_v_nxt;
  usp_pkg::usp_res_t    res_r;
  usp_pkg::usp_state_t  st_r, st_nxt;

  usp_pkg::usp_cls_t    cls;
  usp_pkg::usp_state_t  step_st;
  usp_pkg::usp_res_t    step_res;

  logic adv;     // result register can take a new request
  logic in_acc;  // input request taken this cycle

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !v1_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  usp_classify u_classify (
    .byte_i (byte1_r),
    .cls_o  (cls)
  );

  usp_step u_step (
    .cur_i  (st_r),
    .byte_i (byte1_r),
    .last_i (last1_r),
    .cls_i  (cls),
    .nxt_o  (step_st),
    .res_o  (step_res)
  );

  always_comb begin
    v1_nxt    = in_acc ? 1'b1 : (adv ? 1'b0 : v1_r);
    out_v_nxt = adv ? v1_r : out_v_r;
    st_nxt    = (adv && v1_r) ? step_st : st_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= usp_pkg::USP_STATE_RST;
    end else begin
      v1_r    <= v1_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte1_r <= in_ch.in_byte;
      last1_r <= in_ch.in_last;
    end
    if (adv && v1_r) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.section     = res_r.section;
  assign out_ch.data_byte   = res_r.data_byte;
  assign out_ch.data_valid  = res_r.data_valid;
  assign out_ch.error_code  = res_r.error_code;
  assign out_ch.port_number = res_r.port_number;
  assign out_ch.uri_done    = res_r.uri_done;
  assign out_ch.uri_ok      = res_r.uri_ok;

  // ok only on a clean final result
  `USP_ASSERT_IMP(a_ok_clean, clk, rst_n, out_v_r && res_r.uri_ok,
    res_r.uri_done && (res_r.error_code == usp_pkg::ERR_NONE), "uri_ok without clean done")

  // section bytes never carry the delimiter code
  `USP_ASSERT_IMP(a_data_sec, clk, rst_n, out_v_r && res_r.data_valid,
    res_r.section != usp_pkg::SEC_DELIM, "data on delimiter section")

  // input stalls only when both registers are full and the sink is busy
  `USP_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ch.ready,
    v1_r && out_v_r && !out_ch.ready, "input stalled without cause")

  // a latched error stays until the last byte
  `USP_ASSERT_NXT(a_err_hold, clk, rst_n,
    adv && v1_r && !last1_r && (st_r.err != usp_pkg::ERR_NONE),
    st_r.err == $past(st_r.err), "latched error changed")

  // the last byte returns the parser to reset state
  `USP_ASSERT_NXT(a_last_clear, clk, rst_n, adv && v1_r && last1_r,
    st_r == usp_pkg::USP_STATE_RST, "state not cleared after last")

endmodule

`default_nettype wire
